// ----- src/tct_pkg.sv -----
// Shared types and constants for the TCP connection table.
// Used by tct_ctrl, tct_dp and tcp_connection_table_fsm_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tct_pkg;

    // Table size and derived widths
    localparam int CONNECTIONS = 64;
    localparam int IDX_W       = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

    // Request codes
    localparam logic [2:0] OP_SEGMENT = 3'd0;
    localparam logic [2:0] OP_CONNECT = 3'd1;
    localparam logic [2:0] OP_SEND    = 3'd2;
    localparam logic [2:0] OP_CLOSE   = 3'd3;
    localparam logic [2:0] OP_DRAIN   = 3'd4;

    // Result status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_NO_CONN  = 3'd1;
    localparam logic [2:0] STS_FULL     = 3'd2;
    localparam logic [2:0] STS_WRONG_ST = 3'd3;
    localparam logic [2:0] STS_RX_FULL  = 3'd4;
    localparam logic [2:0] STS_NO_CHG   = 3'd5;

    // Connection states
    localparam logic [3:0] ST_CLOSED      = 4'd0;
    localparam logic [3:0] ST_LISTEN      = 4'd1;
    localparam logic [3:0] ST_SYN_SENT    = 4'd2;
    localparam logic [3:0] ST_ESTABLISHED = 4'd4;
    localparam logic [3:0] ST_FIN_WAIT_1  = 4'd5;
    localparam logic [3:0] ST_FIN_WAIT_2  = 4'd6;
    localparam logic [3:0] ST_CLOSE_WAIT  = 4'd7;
    localparam logic [3:0] ST_CLOSING     = 4'd8;
    localparam logic [3:0] ST_LAST_ACK    = 4'd9;
    localparam logic [3:0] ST_TIME_WAIT   = 4'd10;

    // TCP flag bits
    localparam logic [5:0] FL_FIN = 6'h01;
    localparam logic [5:0] FL_SYN = 6'h02;
    localparam logic [5:0] FL_RST = 6'h04;
    localparam logic [5:0] FL_PSH = 6'h08;
    localparam logic [5:0] FL_ACK = 6'h10;

    // Configuration register indexes
    localparam logic CFG_LOCAL_ADDR = 1'b0;
    localparam logic CFG_RX_CAP     = 1'b1;

    // Reset values and generator constants
    localparam logic [31:0] LOCAL_ADDR_RST = 32'h7F00_0001;
    localparam logic [16:0] RX_CAP_RST     = 17'd65536;
    localparam logic [15:0] PORT_FIRST     = 16'd49152;
    localparam logic [15:0] PORT_LAST      = 16'd65000;
    localparam logic [31:0] ISN_SEED_RST   = 32'h1234_5678;
    localparam logic [31:0] LCG_MUL        = 32'd1103515245;
    localparam logic [31:0] LCG_ADD        = 32'd12345;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] remote_addr;
        logic [15:0] remote_port_in;
        logic [31:0] seg_local_addr;
        logic [15:0] seg_local_port;
        logic [31:0] seg_sequence;
        logic [5:0]  seg_flag_bits;
        logic [15:0] data_len;
        logic [5:0]  slot_in;
    } tct_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot_out;
        logic [3:0]  conn_state_out;
        logic        tx_valid;
        logic [5:0]  tx_flags;
        logic [31:0] tx_sequence;
        logic [31:0] tx_ack;
        logic [31:0] tx_local_addr;
        logic [15:0] tx_local_port;
        logic [31:0] tx_remote_addr;
        logic [15:0] tx_remote_port;
        logic [15:0] drained_len;
    } tct_out_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic look;
        logic exec;
    } tct_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
    } tct_sts_t;

endpackage

`default_nettype wire

// ----- src/tcp_connection_table_fsm_core.sv -----
// Top level of the TCP connection table: controller plus datapath.
// Depends on tct_pkg, tct_ctrl and tct_dp.
//
//  channel | handshake               | payload
//  in      | in_valid / in_ready     | in_data   (tct_in_t)
//  out     | out_valid / out_ready   | out_data  (tct_out_t)
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Each request passes through accept, tuple match and entry read, and execute.
// The tuple compare runs over all entries in parallel, and the entry memory read is registered.
// Execute waits while the result register still holds an untaken beat.
// Reset clears the valid bits at once; no clearing pass is needed.
// Configuration writes are taken every cycle.
`timescale 1ns / 1ps
`default_nettype none

module tcp_connection_table_fsm_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tct_pkg::tct_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tct_pkg::tct_out_t      out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [31:0]       cfg_data
);

    tct_pkg::tct_cmd_t cmd;
    tct_pkg::tct_sts_t sts;

    assign cfg_ready = 1'b1;

    tct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tct_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ----- src/tct_ctrl.sv -----
// Sequencer for the connection table: accept, look up, execute.
// Depends on tct_pkg for command and status types.
`timescale 1ns / 1ps
`default_nettype none

module tct_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tct_pkg::tct_sts_t sts,
    output tct_pkg::tct_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Take a beat only when idle
    assign in_ready   = (state_reg == S_IDLE);
    assign cmd.accept = in_valid && in_ready;
    assign cmd.look   = (state_reg == S_LOOK);
    assign cmd.exec   = (state_reg == S_EXEC) && sts.out_free;

    // Advance the sequence; hold in execute until the result register frees
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == S_LOOK)
        else $error("accepted beat did not start a lookup");

    a_exec_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> sts.out_free)
        else $error("execute issued while result register busy");
`endif

endmodule

`default_nettype wire

// ----- src/tct_dp.sv -----
// Datapath of the connection table: tuple match, entry memory, update and result register.
// Depends on tct_pkg for types and constants.
`timescale 1ns / 1ps
`default_nettype none

module tct_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tct_pkg::tct_cmd_t cmd,
    output tct_pkg::tct_sts_t      sts,
    input  wire tct_pkg::tct_in_t  in_data,
    input  wire logic              cfg_wr,
    input  wire logic              cfg_index,
    input  wire logic [31:0]       cfg_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tct_pkg::tct_out_t      out_data
);

    typedef struct packed {
        logic [31:0] raddr;
        logic [15:0] rport;
        logic [31:0] laddr;
        logic [15:0] lport;
    } tuple_t;

    typedef struct packed {
        logic [3:0]  state;
        logic [31:0] laddr;
        logic [15:0] lport;
        logic [31:0] raddr;
        logic [15:0] rport;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [16:0] recv;
    } rec_t;

    // Configuration and global state
    logic [31:0] local_addr_reg;
    logic [16:0] rx_cap_reg;
    logic [15:0] next_port_reg;
    logic [15:0] next_port_next;
    logic [31:0] seed_reg;
    logic [31:0] seed_next;

    // Per-entry storage
    logic [tct_pkg::CONNECTIONS-1:0] used_reg;
    tuple_t                          tuple_reg [tct_pkg::CONNECTIONS];
    rec_t                            mem [tct_pkg::CONNECTIONS];
    rec_t                            rd_reg;

    // Item and lookup results
    tct_pkg::tct_in_t          item_reg;
    logic [tct_pkg::IDX_W-1:0] idx_reg;
    logic [tct_pkg::IDX_W-1:0] idx_next;
    logic                      ok_reg;
    logic                      ok_next;

    tct_pkg::tct_out_t out_reg;
    tct_pkg::tct_out_t out_next;
    logic              out_valid_reg;

    // Match and allocation search
    logic [tct_pkg::CONNECTIONS-1:0] hit_vec;
    logic [tct_pkg::IDX_W-1:0]       hit_idx;
    logic [tct_pkg::IDX_W-1:0]       free_idx;
    logic [tct_pkg::IDX_W-1:0]       slot_idx;
    logic                            slot_ok;

    // Execute signals
    rec_t        rec_n;
    logic [31:0] em_seq;
    logic        tx;
    logic [5:0]  flags;
    logic [2:0]  status;
    logic [3:0]  st;
    logic        slot_zero;
    logic [15:0] drained;
    logic        wr_en;
    logic        free_en;
    logic        alloc_en;
    logic [17:0] rx_sum;
    logic [16:0] port_inc;

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_reg;

    // Compare the segment tuple against every entry
    always_comb
    begin
        for (int i = 0; i < tct_pkg::CONNECTIONS; i++)
        begin
            hit_vec[i] = used_reg[i]
                && (tuple_reg[i].raddr == item_reg.remote_addr)
                && (tuple_reg[i].rport == item_reg.remote_port_in)
                && (tuple_reg[i].laddr == item_reg.seg_local_addr)
                && (tuple_reg[i].lport == item_reg.seg_local_port);
        end
    end

    // Pick the lowest matching and the lowest free entry
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = tct_pkg::CONNECTIONS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = tct_pkg::IDX_W'(i);
            end
            if (!used_reg[i])
            begin
                free_idx = tct_pkg::IDX_W'(i);
            end
        end
    end

    assign slot_idx = tct_pkg::IDX_W'(item_reg.slot_in);
    assign slot_ok  = (9'(item_reg.slot_in) < 9'(tct_pkg::CONNECTIONS)) && used_reg[slot_idx];

    // Select the entry the request works on
    always_comb
    begin
        case (item_reg.opcode)
            tct_pkg::OP_SEGMENT:
            begin
                idx_next = hit_idx;
                ok_next  = |hit_vec;
            end
            tct_pkg::OP_CONNECT:
            begin
                idx_next = free_idx;
                ok_next  = !(&used_reg);
            end
            default:
            begin
                idx_next = slot_idx;
                ok_next  = slot_ok;
            end
        endcase
    end

    assign rx_sum   = {1'b0, rd_reg.recv} + 18'(item_reg.data_len);
    assign port_inc = {1'b0, next_port_reg} + 17'd1;

    // Run the request against the entry read in the lookup cycle
    always_comb
    begin
        rec_n          = rd_reg;
        em_seq         = rd_reg.seq;
        tx             = 1'b0;
        flags          = '0;
        status         = tct_pkg::STS_OK;
        st             = rd_reg.state;
        slot_zero      = 1'b0;
        drained        = '0;
        wr_en          = 1'b0;
        free_en        = 1'b0;
        alloc_en       = 1'b0;
        seed_next      = seed_reg;
        next_port_next = next_port_reg;
        case (item_reg.opcode)
            tct_pkg::OP_SEGMENT:
            begin
                if (!ok_reg)
                begin
                    status    = tct_pkg::STS_NO_CONN;
                    st        = tct_pkg::ST_CLOSED;
                    slot_zero = 1'b1;
                end
                else
                begin
                    status = tct_pkg::STS_NO_CHG;
                    case (rd_reg.state)
                        tct_pkg::ST_SYN_SENT:
                        begin
                            if ((item_reg.seg_flag_bits & (tct_pkg::FL_SYN | tct_pkg::FL_ACK))
                                == (tct_pkg::FL_SYN | tct_pkg::FL_ACK))
                            begin
                                rec_n.ack   = item_reg.seg_sequence + 32'd1;
                                rec_n.state = tct_pkg::ST_ESTABLISHED;
                                wr_en       = 1'b1;
                                tx          = 1'b1;
                                flags       = tct_pkg::FL_ACK;
                                status      = tct_pkg::STS_OK;
                            end
                            else if ((item_reg.seg_flag_bits & tct_pkg::FL_RST) != '0)
                            begin
                                rec_n.state = tct_pkg::ST_CLOSED;
                                wr_en       = 1'b1;
                                free_en     = 1'b1;
                                status      = tct_pkg::STS_OK;
                            end
                        end
                        tct_pkg::ST_ESTABLISHED:
                        begin
                            if ((item_reg.seg_flag_bits & tct_pkg::FL_FIN) != '0)
                            begin
                                rec_n.ack   = item_reg.seg_sequence
                                    + 32'(item_reg.data_len) + 32'd1;
                                rec_n.state = tct_pkg::ST_CLOSE_WAIT;
                                wr_en       = 1'b1;
                                tx          = 1'b1;
                                flags       = tct_pkg::FL_ACK;
                                status      = tct_pkg::STS_OK;
                            end
                            else if (item_reg.data_len != '0)
                            begin
                                if (rx_sum <= {1'b0, rx_cap_reg})
                                begin
                                    rec_n.recv = rx_sum[16:0];
                                    rec_n.ack  = item_reg.seg_sequence
                                        + 32'(item_reg.data_len);
                                    wr_en      = 1'b1;
                                    tx         = 1'b1;
                                    flags      = tct_pkg::FL_ACK;
                                    status     = tct_pkg::STS_OK;
                                end
                                else
                                begin
                                    status = tct_pkg::STS_RX_FULL;
                                end
                            end
                        end
                        tct_pkg::ST_FIN_WAIT_1:
                        begin
                            if ((item_reg.seg_flag_bits & (tct_pkg::FL_ACK | tct_pkg::FL_FIN))
                                != '0)
                            begin
                                status = tct_pkg::STS_OK;
                                wr_en  = 1'b1;
                                if ((item_reg.seg_flag_bits & tct_pkg::FL_ACK) != '0)
                                begin
                                    rec_n.state = tct_pkg::ST_FIN_WAIT_2;
                                end
                                if ((item_reg.seg_flag_bits & tct_pkg::FL_FIN) != '0)
                                begin
                                    rec_n.ack = item_reg.seg_sequence + 32'd1;
                                    tx        = 1'b1;
                                    flags     = tct_pkg::FL_ACK;
                                    if ((item_reg.seg_flag_bits & tct_pkg::FL_ACK) != '0)
                                    begin
                                        rec_n.state = tct_pkg::ST_TIME_WAIT;
                                    end
                                    else
                                    begin
                                        rec_n.state = tct_pkg::ST_CLOSING;
                                    end
                                end
                            end
                        end
                        tct_pkg::ST_FIN_WAIT_2:
                        begin
                            if ((item_reg.seg_flag_bits & tct_pkg::FL_FIN) != '0)
                            begin
                                rec_n.ack   = item_reg.seg_sequence + 32'd1;
                                rec_n.state = tct_pkg::ST_TIME_WAIT;
                                wr_en       = 1'b1;
                                tx          = 1'b1;
                                flags       = tct_pkg::FL_ACK;
                                status      = tct_pkg::STS_OK;
                            end
                        end
                        tct_pkg::ST_CLOSING:
                        begin
                            if ((item_reg.seg_flag_bits & tct_pkg::FL_ACK) != '0)
                            begin
                                rec_n.state = tct_pkg::ST_TIME_WAIT;
                                wr_en       = 1'b1;
                                status      = tct_pkg::STS_OK;
                            end
                        end
                        tct_pkg::ST_LAST_ACK:
                        begin
                            if ((item_reg.seg_flag_bits & tct_pkg::FL_ACK) != '0)
                            begin
                                rec_n.state = tct_pkg::ST_CLOSED;
                                wr_en       = 1'b1;
                                free_en     = 1'b1;
                                status      = tct_pkg::STS_OK;
                            end
                        end
                        tct_pkg::ST_TIME_WAIT:
                        begin
                            rec_n.state = tct_pkg::ST_CLOSED;
                            wr_en       = 1'b1;
                            free_en     = 1'b1;
                            status      = tct_pkg::STS_OK;
                        end
                        default:
                        begin
                            status = tct_pkg::STS_NO_CHG;
                        end
                    endcase
                    st = rec_n.state;
                end
            end
            tct_pkg::OP_CONNECT:
            begin
                if (!ok_reg)
                begin
                    status    = tct_pkg::STS_FULL;
                    st        = tct_pkg::ST_CLOSED;
                    slot_zero = 1'b1;
                end
                else
                begin
                    // Build a fresh entry and emit SYN with the new sequence
                    seed_next   = seed_reg * tct_pkg::LCG_MUL + tct_pkg::LCG_ADD;
                    rec_n.state = tct_pkg::ST_SYN_SENT;
                    rec_n.laddr = local_addr_reg;
                    rec_n.lport = next_port_reg;
                    rec_n.raddr = item_reg.remote_addr;
                    rec_n.rport = item_reg.remote_port_in;
                    rec_n.seq   = seed_next + 32'd1;
                    rec_n.ack   = '0;
                    rec_n.recv  = '0;
                    em_seq      = seed_next;
                    if (port_inc > {1'b0, tct_pkg::PORT_LAST})
                    begin
                        next_port_next = tct_pkg::PORT_FIRST;
                    end
                    else
                    begin
                        next_port_next = port_inc[15:0];
                    end
                    wr_en    = 1'b1;
                    alloc_en = 1'b1;
                    tx       = 1'b1;
                    flags    = tct_pkg::FL_SYN;
                    st       = tct_pkg::ST_SYN_SENT;
                end
            end
            tct_pkg::OP_SEND,
            tct_pkg::OP_CLOSE,
            tct_pkg::OP_DRAIN:
            begin
                if (!ok_reg)
                begin
                    status    = tct_pkg::STS_NO_CONN;
                    st        = tct_pkg::ST_CLOSED;
                    slot_zero = 1'b1;
                end
                else if (item_reg.opcode == tct_pkg::OP_SEND)
                begin
                    if (rd_reg.state != tct_pkg::ST_ESTABLISHED)
                    begin
                        status = tct_pkg::STS_WRONG_ST;
                    end
                    else
                    begin
                        rec_n.seq = rd_reg.seq + 32'(item_reg.data_len);
                        wr_en     = 1'b1;
                        tx        = 1'b1;
                        flags     = tct_pkg::FL_PSH | tct_pkg::FL_ACK;
                    end
                end
                else if (item_reg.opcode == tct_pkg::OP_CLOSE)
                begin
                    if (rd_reg.state == tct_pkg::ST_ESTABLISHED
                        || rd_reg.state == tct_pkg::ST_CLOSE_WAIT)
                    begin
                        rec_n.state = (rd_reg.state == tct_pkg::ST_ESTABLISHED)
                            ? tct_pkg::ST_FIN_WAIT_1 : tct_pkg::ST_LAST_ACK;
                        rec_n.seq   = rd_reg.seq + 32'd1;
                        wr_en       = 1'b1;
                        tx          = 1'b1;
                        flags       = tct_pkg::FL_FIN | tct_pkg::FL_ACK;
                        st          = rec_n.state;
                    end
                    else if (rd_reg.state == tct_pkg::ST_SYN_SENT
                        || rd_reg.state == tct_pkg::ST_LISTEN)
                    begin
                        rec_n.state = tct_pkg::ST_CLOSED;
                        wr_en       = 1'b1;
                        free_en     = 1'b1;
                        st          = tct_pkg::ST_CLOSED;
                    end
                    else
                    begin
                        status = tct_pkg::STS_NO_CHG;
                    end
                end
                else
                begin
                    // Drain: take the smaller of request and held count
                    if (17'(item_reg.data_len) < rd_reg.recv)
                    begin
                        drained = item_reg.data_len;
                    end
                    else
                    begin
                        drained = rd_reg.recv[15:0];
                    end
                    rec_n.recv = rd_reg.recv - 17'(drained);
                    wr_en      = 1'b1;
                end
            end
            default:
            begin
                status    = tct_pkg::STS_NO_CHG;
                st        = tct_pkg::ST_CLOSED;
                slot_zero = 1'b1;
            end
        endcase
    end

    // Assemble the result beat
    always_comb
    begin
        out_next                = '0;
        out_next.status         = status;
        out_next.slot_out       = slot_zero ? 6'd0 : 6'(idx_reg);
        out_next.conn_state_out = st;
        out_next.drained_len    = drained;
        if (tx)
        begin
            out_next.tx_valid       = 1'b1;
            out_next.tx_flags       = flags;
            out_next.tx_sequence    = em_seq;
            out_next.tx_ack         = rec_n.ack;
            out_next.tx_local_addr  = rec_n.laddr;
            out_next.tx_local_port  = rec_n.lport;
            out_next.tx_remote_addr = rec_n.raddr;
            out_next.tx_remote_port = rec_n.rport;
        end
    end

    // Control state: valid bits, globals, configuration, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            local_addr_reg <= tct_pkg::LOCAL_ADDR_RST;
            rx_cap_reg     <= tct_pkg::RX_CAP_RST;
            next_port_reg  <= tct_pkg::PORT_FIRST;
            seed_reg       <= tct_pkg::ISN_SEED_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (cfg_index == tct_pkg::CFG_LOCAL_ADDR)
                begin
                    local_addr_reg <= cfg_data;
                end
                else
                begin
                    rx_cap_reg <= cfg_data[16:0];
                end
            end
            if (cmd.exec)
            begin
                if (alloc_en)
                begin
                    used_reg[idx_reg] <= 1'b1;
                end
                else if (free_en)
                begin
                    used_reg[idx_reg] <= 1'b0;
                end
                next_port_reg <= next_port_next;
                seed_reg      <= seed_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: item, lookup, tuples, memory, result
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= in_data;
        end
        if (cmd.look)
        begin
            idx_reg <= idx_next;
            ok_reg  <= ok_next;
        end
        rd_reg <= mem[idx_next];
        if (cmd.exec && wr_en)
        begin
            mem[idx_reg] <= rec_n;
        end
        if (cmd.exec && alloc_en)
        begin
            tuple_reg[idx_reg] <= '{raddr: rec_n.raddr, rport: rec_n.rport,
                                    laddr: rec_n.laddr, lport: rec_n.lport};
        end
        if (cmd.exec)
        begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTH
    a_exec_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid_reg)
        else $error("execute did not load the result register");

    a_fail_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status != tct_pkg::STS_OK |-> !out_reg.tx_valid)
        else $error("failed request carries a segment");
`endif

endmodule

`default_nettype wire
